@@ rtl/wsgr_pkg.sv @@
// Shared types, widths and helpers for the wand stroke grid rasterizer.
// No dependencies; imported by every module of the block.
package wsgr_pkg;

  localparam int GRID_SIZE_DEF   = 28;
  localparam int LINE_POINTS_DEF = 5;

  localparam int SAMPLE_W   = 32;  // Q15.16 sample and bias
  localparam int GAIN_W     = 16;  // Q7.8 gain
  localparam int PIX_W      = 16;  // pixel and grid coordinates
  localparam int CANVAS_W   = 12;  // canvas size, also the divisor width
  localparam int ROW_IDX_W  = 5;
  localparam int ROW_BITS_W = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int Q_FRAC     = 24;  // fraction bits of sample times gain

  localparam logic signed [GAIN_W-1:0] GAIN_RST   = 16'sd256;
  localparam logic [CANVAS_W-1:0]      CANVAS_RST = 12'd280;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIAS_X        = 3'd0,
    CFG_BIAS_Y        = 3'd1,
    CFG_GAIN          = 3'd2,
    CFG_CENTER_X      = 3'd3,
    CFG_CENTER_Y      = 3'd4,
    CFG_CANVAS_WIDTH  = 3'd5,
    CFG_CANVAS_HEIGHT = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  // Clamp to the signed 16-bit coordinate range.
  function automatic logic signed [PIX_W-1:0] sat_pix(input logic signed [63:0] v);
    logic signed [PIX_W-1:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -64'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/wsgr_div.sv @@
// Shared radix-2 restoring divider, signed dividend by unsigned divisor,
// quotient truncated toward zero and clamped to 16 bits. Uses wsgr_pkg.
module wsgr_div #(
  parameter int DIV_W = 22
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [DIV_W-1:0]             dividend_i,
  input  logic [wsgr_pkg::CANVAS_W-1:0]       divisor_i,
  output logic                                done_o,
  output logic signed [wsgr_pkg::PIX_W-1:0]   quot_o
);
  import wsgr_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic                   busy_q, fin_q, done_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   neg_q;
  logic [CANVAS_W-1:0]    dvs_q;
  logic [CANVAS_W-1:0]    rem_q;
  logic [DIV_W-1:0]       quo_q;
  logic signed [PIX_W-1:0] quot_q;

  logic [DIV_W-1:0]       dvd_mag;
  logic [CANVAS_W:0]      rem_shift;
  logic                   ge;
  logic [CANVAS_W:0]      rem_sub;
  logic signed [DIV_W:0]  mag_s;
  logic signed [DIV_W:0]  res_s;

  assign dvd_mag   = dividend_i[DIV_W-1] ? DIV_W'(-dividend_i) : DIV_W'(dividend_i);
  assign rem_shift = {rem_q, quo_q[DIV_W-1]};
  assign ge        = rem_shift >= {1'b0, dvs_q};
  assign rem_sub   = rem_shift - {1'b0, dvs_q};
  assign mag_s     = signed'({1'b0, quo_q});
  assign res_s     = neg_q ? -mag_s : mag_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIV_W-1];
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dvd_mag;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[CANVAS_W-1:0] : rem_shift[CANVAS_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
    if (fin_q) begin
      quot_q <= sat_pix(64'(res_s));
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q && !fin_q)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held more than one cycle");

endmodule

@@ rtl/wsgr_bitmap.sv @@
// Stroke bitmap: one row per memory word, registered read, read-modify-write
// marking, per-row valid bits cleared at reset. Uses wsgr_pkg.
module wsgr_bitmap #(
  parameter int GRID_SIZE = wsgr_pkg::GRID_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           mark_i,
  input  logic [$clog2(GRID_SIZE)-1:0]   mark_col_i,
  input  logic [$clog2(GRID_SIZE)-1:0]   mark_row_i,
  input  logic                           read_i,
  input  logic [$clog2(GRID_SIZE)-1:0]   read_row_i,
  output logic [GRID_SIZE-1:0]           row_o
);
  import wsgr_pkg::*;

  localparam int AW = $clog2(GRID_SIZE);

  logic [GRID_SIZE-1:0] mem_q [GRID_SIZE];
  logic [GRID_SIZE-1:0] row_vld_q;
  logic                 rd_vld_q;
  logic                 wr_pend_q;
  logic [GRID_SIZE-1:0] rd_q;
  logic [AW-1:0]        wr_col_q, wr_row_q;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [GRID_SIZE-1:0] cur_row;

  assign rd_en   = mark_i || read_i;
  assign rd_addr = mark_i ? mark_row_i : read_row_i;
  assign cur_row = rd_vld_q ? rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= mark_i;
      if (rd_en) begin
        rd_vld_q <= row_vld_q[rd_addr];
      end
      if (wr_pend_q) begin
        row_vld_q[wr_row_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
    if (mark_i) begin
      wr_col_q <= mark_col_i;
      wr_row_q <= mark_row_i;
    end
    if (wr_pend_q) begin
      mem_q[wr_row_q] <= cur_row | (GRID_SIZE'(1) << wr_col_q);
    end
  end

  assign row_o = cur_row;

  // the row being written back must not be overtaken by another access
  a_no_access_during_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> !mark_i && !read_i)
    else $error("bitmap access collides with pending write");

endmodule

@@ rtl/wand_stroke_grid_rasterizer.sv @@
// Top level of the wand stroke grid rasterizer: config registers, sequencer,
// pixel multiplier, and instances of wsgr_div and wsgr_bitmap. Uses wsgr_pkg.
//
// One item at a time. A row read passes through ST_RD_ISSUE and ST_FINISH
// before its result is registered. A wand sample runs multiply and clamp
// (x then y), then 4 + 2*LINE_POINTS divisions on the single shared divider,
// with DIV_W = 17 + max(clog2(GRID_SIZE), clog2(LINE_POINTS-1)), which is 22
// at the defaults, marking each line point in the bitmap. The bitmap keeps
// one valid bit per row, cleared by reset, so the block is usable right after
// reset with no clearing pass. A finished result sits in the output register
// while the next item is accepted.
module wand_stroke_grid_rasterizer #(
  parameter int GRID_SIZE   = wsgr_pkg::GRID_SIZE_DEF,
  parameter int LINE_POINTS = wsgr_pkg::LINE_POINTS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  operation_i,
  input  logic signed [wsgr_pkg::SAMPLE_W-1:0]  sample_x_i,
  input  logic signed [wsgr_pkg::SAMPLE_W-1:0]  sample_y_i,
  input  logic [wsgr_pkg::ROW_IDX_W-1:0]        row_index_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [wsgr_pkg::PIX_W-1:0]     grid_col_o,
  output logic signed [wsgr_pkg::PIX_W-1:0]     grid_row_o,
  output logic                                  inside_grid_o,
  output logic [wsgr_pkg::ROW_BITS_W-1:0]       row_bits_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [wsgr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [wsgr_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import wsgr_pkg::*;

  localparam int AW     = $clog2(GRID_SIZE);
  localparam int LINE_N = LINE_POINTS - 1;
  localparam int CG     = $clog2(GRID_SIZE);
  localparam int CL     = $clog2(LINE_N);
  localparam int DIV_W  = 17 + ((CG > CL) ? CG : CL);
  localparam int PT_W   = (LINE_POINTS > 2) ? $clog2(LINE_POINTS) : 1;
  localparam int SUM_W  = SAMPLE_W + 1;
  localparam int PROD_W = SUM_W + GAIN_W;
  localparam int Q_W    = PROD_W + 1;
  localparam int RIDX_W = ROW_IDX_W + AW + 1;
  localparam int EXT_W  = GRID_SIZE + ROW_BITS_W;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b0000000001,
    ST_RD_ISSUE  = 10'b0000000010,
    ST_MUL       = 10'b0000000100,
    ST_PIX       = 10'b0000001000,
    ST_DIV_GO    = 10'b0000010000,
    ST_DIV_WAIT  = 10'b0000100000,
    ST_LINE_INIT = 10'b0001000000,
    ST_MARK      = 10'b0010000000,
    ST_LINE_NEXT = 10'b0100000000,
    ST_FINISH    = 10'b1000000000
  } st_e;

  typedef enum logic [1:0] {
    JOB_GX = 2'd0,
    JOB_GY = 2'd1,
    JOB_OX = 2'd2,
    JOB_OY = 2'd3
  } job_e;

  // configuration
  logic signed [SAMPLE_W-1:0] bias_x_q, bias_y_q;
  logic signed [GAIN_W-1:0]   gain_q;
  logic signed [PIX_W-1:0]    center_x_q, center_y_q;
  logic [CANVAS_W-1:0]        canvas_w_q, canvas_h_q;

  // sequencer control
  st_e                        state_q, state_d;
  job_e                       job_q;
  logic                       ax_q;
  logic                       line_q;
  logic [PT_W-1:0]            pt_q;
  logic                       out_valid_q;

  // item and working registers
  logic                       op_q;
  logic signed [SAMPLE_W-1:0] sx_q, sy_q;
  logic [ROW_IDX_W-1:0]       row_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [PIX_W-1:0]    px_q, py_q, prev_px_q, prev_py_q;
  logic signed [PIX_W-1:0]    gx_q, gy_q, ox_q, oy_q, mx_q, my_q;
  logic signed [PIX_W:0]      dx_q, dy_q;
  logic signed [DIV_W-1:0]    acc_x_q, acc_y_q;

  // output register
  logic signed [PIX_W-1:0]    out_col_q, out_row_q;
  logic                       out_inside_q;
  logic [ROW_BITS_W-1:0]      out_bits_q;

  logic                       in_accept, out_free;
  logic signed [SUM_W-1:0]    mul_sum;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [Q_W-1:0]      q24, q_shift, q_trunc;
  logic signed [PIX_W-1:0]    pix_d;
  logic signed [PIX_W-1:0]    grid_src;
  logic [CANVAS_W-1:0]        canvas_sel;
  logic signed [DIV_W-1:0]    div_dividend;
  logic [CANVAS_W-1:0]        div_divisor;
  logic                       div_done;
  logic signed [PIX_W-1:0]    div_quot;
  logic [RIDX_W-1:0]          row_ext_idx;
  logic                       row_ok;
  logic                       pt_inside, new_inside;
  logic                       bm_mark, bm_read;
  logic [GRID_SIZE-1:0]       bm_row;
  logic [EXT_W-1:0]           row_ext;

  function automatic logic on_grid(input logic signed [PIX_W-1:0] v);
    return !v[PIX_W-1] && (v < PIX_W'(GRID_SIZE));
  endfunction

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // pixel mapping: (c * 2^24 - (s + b) * g) / 2^24, truncated toward zero
  assign mul_sum = SUM_W'(ax_q ? sy_q : sx_q) + SUM_W'(ax_q ? bias_y_q : bias_x_q);
  assign prod_d  = PROD_W'(mul_sum) * PROD_W'(gain_q);
  assign q24     = (Q_W'(ax_q ? center_y_q : center_x_q) <<< Q_FRAC) - Q_W'(prod_q);
  assign q_shift = q24 >>> Q_FRAC;
  assign q_trunc = (q24[Q_W-1] && (q24[Q_FRAC-1:0] != '0)) ? q_shift + Q_W'(1) : q_shift;
  assign pix_d   = sat_pix(64'(q_trunc));

  // divider operand select
  always_comb begin
    grid_src   = px_q;
    canvas_sel = canvas_w_q;
    case (job_q)
      JOB_GX: begin grid_src = px_q;      canvas_sel = canvas_w_q; end
      JOB_GY: begin grid_src = py_q;      canvas_sel = canvas_h_q; end
      JOB_OX: begin grid_src = prev_px_q; canvas_sel = canvas_w_q; end
      JOB_OY: begin grid_src = prev_py_q; canvas_sel = canvas_h_q; end
      default: ;
    endcase
    if (line_q) begin
      div_dividend = ax_q ? acc_y_q : acc_x_q;
      div_divisor  = CANVAS_W'(LINE_N);
    end else begin
      div_dividend = DIV_W'(grid_src) * DIV_W'(GRID_SIZE);
      div_divisor  = (canvas_sel == '0) ? CANVAS_W'(1) : canvas_sel;
    end
  end

  assign row_ext_idx = RIDX_W'(row_q);
  assign row_ok      = row_ext_idx < RIDX_W'(GRID_SIZE);
  assign pt_inside   = on_grid(mx_q) && on_grid(my_q);
  assign new_inside  = on_grid(gx_q) && on_grid(gy_q);
  assign bm_mark     = (state_q == ST_MARK) && pt_inside;
  assign bm_read     = (state_q == ST_RD_ISSUE) && row_ok;
  assign row_ext     = EXT_W'(bm_row);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (operation_i == OP_READ) ? ST_RD_ISSUE : ST_MUL;
        end
      end
      ST_RD_ISSUE:  state_d = ST_FINISH;
      ST_MUL:       state_d = ST_PIX;
      ST_PIX:       state_d = ax_q ? ST_DIV_GO : ST_MUL;
      ST_DIV_GO:    state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (line_q) begin
            state_d = ax_q ? ST_MARK : ST_DIV_GO;
          end else begin
            state_d = (job_q == JOB_OY) ? ST_LINE_INIT : ST_DIV_GO;
          end
        end
      end
      ST_LINE_INIT: state_d = ST_DIV_GO;
      ST_MARK:      state_d = ST_LINE_NEXT;
      ST_LINE_NEXT: state_d = (pt_q == PT_W'(LINE_N)) ? ST_FINISH : ST_DIV_GO;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= JOB_GX;
      ax_q        <= 1'b0;
      line_q      <= 1'b0;
      pt_q        <= '0;
      out_valid_q <= 1'b0;
      prev_px_q   <= '0;
      prev_py_q   <= '0;
      bias_x_q    <= '0;
      bias_y_q    <= '0;
      gain_q      <= GAIN_RST;
      center_x_q  <= '0;
      center_y_q  <= '0;
      canvas_w_q  <= CANVAS_RST;
      canvas_h_q  <= CANVAS_RST;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_BIAS_X:        bias_x_q   <= cfg_data_i;
          CFG_BIAS_Y:        bias_y_q   <= cfg_data_i;
          CFG_GAIN:          gain_q     <= cfg_data_i[GAIN_W-1:0];
          CFG_CENTER_X:      center_x_q <= cfg_data_i[PIX_W-1:0];
          CFG_CENTER_Y:      center_y_q <= cfg_data_i[PIX_W-1:0];
          CFG_CANVAS_WIDTH:  canvas_w_q <= cfg_data_i[CANVAS_W-1:0];
          CFG_CANVAS_HEIGHT: canvas_h_q <= cfg_data_i[CANVAS_W-1:0];
          default: ;
        endcase
      end

      // a new result may replace the one leaving in the same cycle
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          ax_q   <= 1'b0;
          line_q <= 1'b0;
          job_q  <= JOB_GX;
        end
        ST_PIX: ax_q <= !ax_q;
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (line_q) begin
              ax_q <= !ax_q;
            end else if (job_q != JOB_OY) begin
              job_q <= job_e'(job_q + 2'd1);
            end
          end
        end
        ST_LINE_INIT: begin
          line_q <= 1'b1;
          ax_q   <= 1'b0;
          pt_q   <= '0;
        end
        ST_LINE_NEXT: begin
          ax_q <= 1'b0;
          if (pt_q != PT_W'(LINE_N)) begin
            pt_q <= pt_q + PT_W'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            if (op_q == OP_SAMPLE) begin
              prev_px_q <= px_q;
              prev_py_q <= py_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= operation_i;
      sx_q  <= sample_x_i;
      sy_q  <= sample_y_i;
      row_q <= row_index_i;
    end
    case (state_q)
      ST_MUL: prod_q <= prod_d;
      ST_PIX: begin
        if (ax_q) begin
          py_q <= pix_d;
        end else begin
          px_q <= pix_d;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (line_q) begin
            if (ax_q) begin
              my_q <= div_quot;
            end else begin
              mx_q <= div_quot;
            end
          end else begin
            case (job_q)
              JOB_GX: gx_q <= div_quot;
              JOB_GY: gy_q <= div_quot;
              JOB_OX: ox_q <= div_quot;
              JOB_OY: oy_q <= div_quot;
              default: ;
            endcase
          end
        end
      end
      ST_LINE_INIT: begin
        acc_x_q <= DIV_W'(ox_q) * DIV_W'(LINE_N);
        acc_y_q <= DIV_W'(oy_q) * DIV_W'(LINE_N);
        dx_q    <= (PIX_W + 1)'(gx_q) - (PIX_W + 1)'(ox_q);
        dy_q    <= (PIX_W + 1)'(gy_q) - (PIX_W + 1)'(oy_q);
      end
      ST_LINE_NEXT: begin
        acc_x_q <= acc_x_q + DIV_W'(dx_q);
        acc_y_q <= acc_y_q + DIV_W'(dy_q);
      end
      ST_FINISH: begin
        if (out_free) begin
          if (op_q == OP_READ) begin
            out_col_q    <= '0;
            out_row_q    <= '0;
            out_inside_q <= 1'b0;
            out_bits_q   <= row_ok ? row_ext[ROW_BITS_W-1:0] : '0;
          end else begin
            out_col_q    <= gx_q;
            out_row_q    <= gy_q;
            out_inside_q <= new_inside;
            out_bits_q   <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  wsgr_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_DIV_GO),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  wsgr_bitmap #(
    .GRID_SIZE (GRID_SIZE)
  ) u_bitmap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mark_i     (bm_mark),
    .mark_col_i (mx_q[AW-1:0]),
    .mark_row_i (my_q[AW-1:0]),
    .read_i     (bm_read),
    .read_row_i (row_ext_idx[AW-1:0]),
    .row_o      (bm_row)
  );

  assign out_valid_o   = out_valid_q;
  assign grid_col_o    = out_col_q;
  assign grid_row_o    = out_row_q;
  assign inside_grid_o = out_inside_q;
  assign row_bits_o    = out_bits_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("block ready again right after accepting an item");

  a_inside_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && inside_grid_o |->
      !grid_col_o[PIX_W-1] && (grid_col_o < PIX_W'(GRID_SIZE)) &&
      !grid_row_o[PIX_W-1] && (grid_row_o < PIX_W'(GRID_SIZE)))
    else $error("inside flag set for a point off the grid");

  a_read_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (row_bits_o != '0) |->
      (grid_col_o == '0) && (grid_row_o == '0) && !inside_grid_o)
    else $error("row read result carries grid fields");

endmodule
